// ----- rtl/core/famf_pkg.sv -----
// Shared constants and types for the flow average and median filter.
package famf_pkg;

    localparam int DATA_W       = 16;
    localparam int MODE_W       = 2;
    localparam int AVG_TAPS     = 20;
    localparam int MED_TAPS     = 11;

    localparam int AVG_IDX_W    = $clog2(AVG_TAPS);
    localparam int MED_IDX_W    = $clog2(MED_TAPS);
    localparam int CNT_W        = (AVG_IDX_W > MED_IDX_W) ? AVG_IDX_W : MED_IDX_W;
    localparam int MED_CNT_W    = $clog2(MED_TAPS + 1);
    localparam int MED_RANK     = MED_TAPS / 2;

    localparam int SUM_W        = DATA_W + AVG_IDX_W;
    localparam int RECIP_SHIFT  = SUM_W + AVG_IDX_W;
    localparam int RECIP_W      = SUM_W + 1;
    localparam int PROD_W       = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_AVG    = 2'd1,
        MODE_MED    = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_SUM,
        ST_AVG_ABS,
        ST_AVG_MUL,
        ST_AVG_DIV,
        ST_MED_SCAN,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/core/flow_average_median_filter_top.sv -----
// Top level of the two-channel flow smoother with moving average and moving median.
// Average mode: one ring entry per cycle goes through the accumulator, then magnitude,
// reciprocal multiply and sign.
// Median mode: one candidate per cycle is ranked against all ring entries.
// Modes zero and three give nothing. A new item is taken only while the block is idle.
// A stalled result holds the block. Reset clears rings, slots and output valid, mode average.
module flow_average_median_filter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [famf_pkg::DATA_W-1:0] flow_x,
    input  logic signed [famf_pkg::DATA_W-1:0] flow_y,
    input  logic                              sample_valid,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [famf_pkg::DATA_W-1:0] filtered_x,
    output logic signed [famf_pkg::DATA_W-1:0] filtered_y,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [famf_pkg::MODE_W-1:0]       cfg_data
);

    famf_pkg::state_t state_reg, state_next;
    logic [famf_pkg::MODE_W-1:0] mode_reg, mode_next;

    logic signed [famf_pkg::DATA_W-1:0] avg_ring_x_reg [famf_pkg::AVG_TAPS];
    logic signed [famf_pkg::DATA_W-1:0] avg_ring_y_reg [famf_pkg::AVG_TAPS];
    logic signed [famf_pkg::DATA_W-1:0] med_ring_x_reg [famf_pkg::MED_TAPS];
    logic signed [famf_pkg::DATA_W-1:0] med_ring_y_reg [famf_pkg::MED_TAPS];
    logic [famf_pkg::AVG_IDX_W-1:0] avg_slot_reg, avg_slot_next;
    logic [famf_pkg::MED_IDX_W-1:0] med_slot_reg, med_slot_next;

    logic [famf_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic signed [famf_pkg::SUM_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [famf_pkg::SUM_W-1:0] mag_x_reg, mag_x_next, mag_y_reg, mag_y_next;
    logic neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [famf_pkg::PROD_W-1:0] prod_x_reg, prod_x_next, prod_y_reg, prod_y_next;
    logic signed [famf_pkg::DATA_W-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic found_x_reg, found_x_next, found_y_reg, found_y_next;
    logic out_valid_reg, out_valid_next;
    logic signed [famf_pkg::DATA_W-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;

    logic accept;
    logic load_out;
    logic last_avg;
    logic last_med;
    logic signed [famf_pkg::DATA_W-1:0] sx;
    logic signed [famf_pkg::DATA_W-1:0] sy;
    logic signed [famf_pkg::DATA_W-1:0] avg_ent_x, avg_ent_y, cand_x, cand_y;
    logic [famf_pkg::MED_TAPS-1:0] lt_x, le_x, lt_y, le_y;
    logic [famf_pkg::MED_CNT_W-1:0] less_x, leq_x, less_y, leq_y;
    logic hit_x, hit_y;
    logic [famf_pkg::DATA_W-1:0] q_x, q_y;

    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign filtered_x = out_x_reg;
    assign filtered_y = out_y_reg;
    assign last_avg  = (idx_reg == famf_pkg::CNT_W'(famf_pkg::AVG_TAPS - 1));
    assign last_med  = (idx_reg == famf_pkg::CNT_W'(famf_pkg::MED_TAPS - 1));
    assign sx        = sample_valid ? flow_x : '0;
    assign sy        = sample_valid ? flow_y : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            famf_pkg::ST_IDLE:
            begin
                if (accept && mode_reg == famf_pkg::MODE_AVG)
                begin
                    state_next = famf_pkg::ST_AVG_SUM;
                end
                else if (accept && mode_reg == famf_pkg::MODE_MED)
                begin
                    state_next = famf_pkg::ST_MED_SCAN;
                end
            end
            famf_pkg::ST_AVG_SUM:
            begin
                if (last_avg)
                begin
                    state_next = famf_pkg::ST_AVG_ABS;
                end
            end
            famf_pkg::ST_AVG_ABS:  state_next = famf_pkg::ST_AVG_MUL;
            famf_pkg::ST_AVG_MUL:  state_next = famf_pkg::ST_AVG_DIV;
            famf_pkg::ST_AVG_DIV:  state_next = famf_pkg::ST_DONE;
            famf_pkg::ST_MED_SCAN:
            begin
                if (last_med)
                begin
                    state_next = famf_pkg::ST_DONE;
                end
            end
            famf_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = famf_pkg::ST_IDLE;
                end
            end
            default: state_next = famf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        load_out = 1'b0;
        unique case (state_reg)
            famf_pkg::ST_IDLE: in_stall = 1'b0;
            famf_pkg::ST_DONE: load_out = !out_valid_reg || !out_stall;
            default:
            begin
                in_stall = 1'b1;
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        avg_ent_x = avg_ring_x_reg[idx_reg[famf_pkg::AVG_IDX_W-1:0]];
        avg_ent_y = avg_ring_y_reg[idx_reg[famf_pkg::AVG_IDX_W-1:0]];
        cand_x    = med_ring_x_reg[idx_reg[famf_pkg::MED_IDX_W-1:0]];
        cand_y    = med_ring_y_reg[idx_reg[famf_pkg::MED_IDX_W-1:0]];
        for (int j = 0; j < famf_pkg::MED_TAPS; j++)
        begin
            lt_x[j] = med_ring_x_reg[j] < cand_x;
            le_x[j] = med_ring_x_reg[j] <= cand_x;
            lt_y[j] = med_ring_y_reg[j] < cand_y;
            le_y[j] = med_ring_y_reg[j] <= cand_y;
        end
        less_x = famf_pkg::MED_CNT_W'($countones(lt_x));
        leq_x  = famf_pkg::MED_CNT_W'($countones(le_x));
        less_y = famf_pkg::MED_CNT_W'($countones(lt_y));
        leq_y  = famf_pkg::MED_CNT_W'($countones(le_y));
        hit_x  = (less_x <= famf_pkg::MED_CNT_W'(famf_pkg::MED_RANK)) &&
                 (leq_x > famf_pkg::MED_CNT_W'(famf_pkg::MED_RANK));
        hit_y  = (less_y <= famf_pkg::MED_CNT_W'(famf_pkg::MED_RANK)) &&
                 (leq_y > famf_pkg::MED_CNT_W'(famf_pkg::MED_RANK));
        q_x    = prod_x_reg[famf_pkg::RECIP_SHIFT +: famf_pkg::DATA_W];
        q_y    = prod_y_reg[famf_pkg::RECIP_SHIFT +: famf_pkg::DATA_W];
    end

    always_comb
    begin
        mode_next     = mode_reg;
        avg_slot_next = avg_slot_reg;
        med_slot_next = med_slot_reg;
        idx_next      = idx_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        mag_x_next    = mag_x_reg;
        mag_y_next    = mag_y_reg;
        neg_x_next    = neg_x_reg;
        neg_y_next    = neg_y_reg;
        prod_x_next   = prod_x_reg;
        prod_y_next   = prod_y_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        found_x_next  = found_x_reg;
        found_y_next  = found_y_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_valid_next = out_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            mode_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            famf_pkg::ST_IDLE:
            begin
                idx_next     = '0;
                sum_x_next   = '0;
                sum_y_next   = '0;
                found_x_next = 1'b0;
                found_y_next = 1'b0;
                if (accept && mode_reg == famf_pkg::MODE_AVG)
                begin
                    avg_slot_next = (avg_slot_reg == famf_pkg::AVG_IDX_W'(famf_pkg::AVG_TAPS - 1))
                                    ? '0 : avg_slot_reg + 1'b1;
                end
                if (accept && mode_reg == famf_pkg::MODE_MED)
                begin
                    med_slot_next = (med_slot_reg == famf_pkg::MED_IDX_W'(famf_pkg::MED_TAPS - 1))
                                    ? '0 : med_slot_reg + 1'b1;
                end
            end
            famf_pkg::ST_AVG_SUM:
            begin
                sum_x_next = sum_x_reg +
                    {{(famf_pkg::SUM_W - famf_pkg::DATA_W){avg_ent_x[famf_pkg::DATA_W-1]}},
                     avg_ent_x};
                sum_y_next = sum_y_reg +
                    {{(famf_pkg::SUM_W - famf_pkg::DATA_W){avg_ent_y[famf_pkg::DATA_W-1]}},
                     avg_ent_y};
                idx_next = idx_reg + 1'b1;
            end
            famf_pkg::ST_AVG_ABS:
            begin
                neg_x_next = sum_x_reg[famf_pkg::SUM_W-1];
                neg_y_next = sum_y_reg[famf_pkg::SUM_W-1];
                mag_x_next = sum_x_reg[famf_pkg::SUM_W-1] ? -sum_x_reg : sum_x_reg;
                mag_y_next = sum_y_reg[famf_pkg::SUM_W-1] ? -sum_y_reg : sum_y_reg;
            end
            famf_pkg::ST_AVG_MUL:
            begin
                prod_x_next = famf_pkg::PROD_W'(mag_x_reg) * famf_pkg::PROD_W'(famf_pkg::RECIP);
                prod_y_next = famf_pkg::PROD_W'(mag_y_reg) * famf_pkg::PROD_W'(famf_pkg::RECIP);
            end
            famf_pkg::ST_AVG_DIV:
            begin
                res_x_next = neg_x_reg ? -q_x : q_x;
                res_y_next = neg_y_reg ? -q_y : q_y;
            end
            famf_pkg::ST_MED_SCAN:
            begin
                if (!found_x_reg && hit_x)
                begin
                    res_x_next   = cand_x;
                    found_x_next = 1'b1;
                end
                if (!found_y_reg && hit_y)
                begin
                    res_y_next   = cand_y;
                    found_y_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            famf_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= famf_pkg::ST_IDLE;
            mode_reg      <= famf_pkg::MODE_AVG;
            avg_slot_reg  <= '0;
            med_slot_reg  <= '0;
            idx_reg       <= '0;
            found_x_reg   <= 1'b0;
            found_y_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < famf_pkg::AVG_TAPS; k++)
            begin
                avg_ring_x_reg[k] <= '0;
                avg_ring_y_reg[k] <= '0;
            end
            for (int k = 0; k < famf_pkg::MED_TAPS; k++)
            begin
                med_ring_x_reg[k] <= '0;
                med_ring_y_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            avg_slot_reg  <= avg_slot_next;
            med_slot_reg  <= med_slot_next;
            idx_reg       <= idx_next;
            found_x_reg   <= found_x_next;
            found_y_reg   <= found_y_next;
            out_valid_reg <= out_valid_next;
            if (accept && mode_reg == famf_pkg::MODE_AVG)
            begin
                avg_ring_x_reg[avg_slot_reg] <= sx;
                avg_ring_y_reg[avg_slot_reg] <= sy;
            end
            if (accept && mode_reg == famf_pkg::MODE_MED)
            begin
                med_ring_x_reg[med_slot_reg] <= sx;
                med_ring_y_reg[med_slot_reg] <= sy;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_x_reg  <= sum_x_next;
        sum_y_reg  <= sum_y_next;
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
    end

    a_avg_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == famf_pkg::MODE_AVG) |=> (state_reg == famf_pkg::ST_AVG_SUM))
        else $error("Average item did not start the accumulation.");

    a_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_reg == famf_pkg::MODE_OFF || mode_reg == famf_pkg::MODE_UNUSED))
        |=> (state_reg == famf_pkg::ST_IDLE && $stable(avg_slot_reg) && $stable(med_slot_reg)))
        else $error("Item without filtering changed the filter state.");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == famf_pkg::ST_DONE))
        else $error("Result appeared outside the completion state.");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (avg_slot_reg < famf_pkg::AVG_IDX_W'(famf_pkg::AVG_TAPS)) &&
        (med_slot_reg < famf_pkg::MED_IDX_W'(famf_pkg::MED_TAPS)))
        else $error("Ring slot out of range.");

endmodule

// ----- verif/flow_filter_checker.sv -----
// Checker that predicts and compares the filtered flow vectors of the smoother.
`timescale 1ns / 1ps

module flow_filter_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [famf_pkg::DATA_W-1:0] flow_x,
    input  logic signed [famf_pkg::DATA_W-1:0] flow_y,
    input  logic                               sample_valid,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [famf_pkg::DATA_W-1:0] filtered_x,
    input  logic signed [famf_pkg::DATA_W-1:0] filtered_y,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [famf_pkg::MODE_W-1:0]        cfg_data,
    output int                                 fail_count,
    output int                                 pending
);

    typedef struct packed {
        logic signed [famf_pkg::DATA_W-1:0] x;
        logic signed [famf_pkg::DATA_W-1:0] y;
    } flow_vec_t;

    famf_pkg::mode_t                    mode;
    logic signed [famf_pkg::DATA_W-1:0] avg_ring [2][famf_pkg::AVG_TAPS];
    logic signed [famf_pkg::DATA_W-1:0] med_ring [2][famf_pkg::MED_TAPS];
    int                                 avg_slot;
    int                                 med_slot;
    int                                 fails;
    flow_vec_t                          expected_vectors [$];

    function automatic logic signed [famf_pkg::DATA_W-1:0] ring_mean(input int ch);
        int total;
        total = 0;
        for (int k = 0; k < famf_pkg::AVG_TAPS; k++)
        begin
            total += avg_ring[ch][k];
        end
        return famf_pkg::DATA_W'(total / famf_pkg::AVG_TAPS);
    endfunction

    // Sorts a copy so that the ring order is left intact.
    function automatic logic signed [famf_pkg::DATA_W-1:0] ring_median(input int ch);
        logic signed [famf_pkg::DATA_W-1:0] work [famf_pkg::MED_TAPS];
        logic signed [famf_pkg::DATA_W-1:0] held;
        int                                 m;
        for (int k = 0; k < famf_pkg::MED_TAPS; k++)
        begin
            work[k] = med_ring[ch][k];
        end
        for (int k = 1; k < famf_pkg::MED_TAPS; k++)
        begin
            held = work[k];
            m = k;
            while (m > 0 && work[m-1] > held)
            begin
                work[m] = work[m-1];
                m--;
            end
            work[m] = held;
        end
        return work[famf_pkg::MED_RANK];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flow_vec_t got;
        flow_vec_t want;
        flow_vec_t sample;
        if (!rst_n)
        begin
            mode = famf_pkg::MODE_AVG;
            avg_slot = 0;
            med_slot = 0;
            fails = 0;
            expected_vectors.delete();
            for (int c = 0; c < 2; c++)
            begin
                for (int k = 0; k < famf_pkg::AVG_TAPS; k++)
                begin
                    avg_ring[c][k] = '0;
                end
                for (int k = 0; k < famf_pkg::MED_TAPS; k++)
                begin
                    med_ring[c][k] = '0;
                end
            end
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.x = filtered_x;
                got.y = filtered_y;
                if (expected_vectors.size() == 0)
                begin
                    $error("unexpected result: filtered_x %0d, filtered_y %0d", got.x, got.y);
                    fails++;
                end
                else
                begin
                    want = expected_vectors.pop_front();
                    if (got.x !== want.x)
                    begin
                        $error("filtered_x: expected %0d, actual %0d", want.x, got.x);
                        fails++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("filtered_y: expected %0d, actual %0d", want.y, got.y);
                        fails++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                sample.x = sample_valid ? flow_x : '0;
                sample.y = sample_valid ? flow_y : '0;
                case (mode)
                    famf_pkg::MODE_AVG:
                    begin
                        avg_ring[0][avg_slot] = sample.x;
                        avg_ring[1][avg_slot] = sample.y;
                        avg_slot = (avg_slot + 1 >= famf_pkg::AVG_TAPS) ? 0 : avg_slot + 1;
                        want.x = ring_mean(0);
                        want.y = ring_mean(1);
                        expected_vectors.push_back(want);
                    end
                    famf_pkg::MODE_MED:
                    begin
                        med_ring[0][med_slot] = sample.x;
                        med_ring[1][med_slot] = sample.y;
                        med_slot = (med_slot + 1 >= famf_pkg::MED_TAPS) ? 0 : med_slot + 1;
                        want.x = ring_median(0);
                        want.y = ring_median(1);
                        expected_vectors.push_back(want);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cfg_valid && cfg_ready)
            begin
                mode = famf_pkg::mode_t'(cfg_data);
            end
        end
        fail_count <= fails;
        pending <= expected_vectors.size();
    end

endmodule

// ----- verif/flow_average_median_filter_top_tb.sv -----
// Testbench top that drives the flow smoother and reports the verdict.
`timescale 1ns / 1ps

module flow_average_median_filter_top_tb;

    localparam int ITEM_COUNT    = 1800;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 4000;

    // Directed vectors packed as {sample_valid, flow_x, flow_y}.
    localparam logic [32:0] EDGE_VECTORS [8] = '{
        {1'b1, 16'h7fff, 16'h8000},
        {1'b1, 16'h8000, 16'h7fff},
        {1'b0, 16'h1234, 16'habcd},
        {1'b1, 16'hffff, 16'h0001},
        {1'b1, 16'h0000, 16'h0000},
        {1'b1, 16'h7fff, 16'h7fff},
        {1'b1, 16'h8000, 16'h8000},
        {1'b1, 16'h5555, 16'haaaa}
    };

    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               in_valid     = 1'b0;
    logic                               in_stall;
    logic signed [famf_pkg::DATA_W-1:0] flow_x       = '0;
    logic signed [famf_pkg::DATA_W-1:0] flow_y       = '0;
    logic                               sample_valid = 1'b0;
    logic                               out_valid;
    logic                               out_stall    = 1'b0;
    logic signed [famf_pkg::DATA_W-1:0] filtered_x;
    logic signed [famf_pkg::DATA_W-1:0] filtered_y;
    logic                               cfg_valid    = 1'b0;
    logic                               cfg_ready;
    logic [famf_pkg::MODE_W-1:0]        cfg_data     = famf_pkg::MODE_AVG;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit calm        = 1'b0;

    flow_average_median_filter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .flow_x       (flow_x),
        .flow_y       (flow_y),
        .sample_valid (sample_valid),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered_x   (filtered_x),
        .filtered_y   (filtered_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    flow_filter_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .flow_x       (flow_x),
        .flow_y       (flow_y),
        .sample_valid (sample_valid),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered_x   (filtered_x),
        .filtered_y   (filtered_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int r;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (calm || r < 70)
            begin
                out_stall <= 1'b0;
            end
            else if (r < 95)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 50)) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [famf_pkg::DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3, 4:    return famf_pkg::DATA_W'($urandom_range(0, 1023) - 512);
            5:       return famf_pkg::DATA_W'($urandom_range(0, 7));
            default: return famf_pkg::DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [famf_pkg::DATA_W-1:0] x,
                             input logic [famf_pkg::DATA_W-1:0] y,
                             input logic v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        flow_x       <= x;
        flow_y       <= y;
        sample_valid <= v;
        do @(posedge clk); while (in_stall);
    endtask

    // Waits until every expected item has come back and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input famf_pkg::mode_t m);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_edges(input int count);
        for (int k = 0; k < count; k++)
        begin
            send_item(EDGE_VECTORS[k][31:16], EDGE_VECTORS[k][15:0], EDGE_VECTORS[k][32]);
        end
    endtask

    initial
    begin
        int              sent;
        int              length;
        int              r;
        famf_pkg::mode_t m;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_edges(8);
        set_mode(famf_pkg::MODE_MED);
        send_edges(8);
        set_mode(famf_pkg::MODE_OFF);
        send_edges(2);
        set_mode(famf_pkg::MODE_UNUSED);
        send_edges(2);
        set_mode(famf_pkg::MODE_AVG);
        send_edges(2);
        sent = 22;

        while (sent < ITEM_COUNT)
        begin
            r = $urandom_range(0, 9);
            m = (r == 0) ? famf_pkg::MODE_OFF : (r == 1) ? famf_pkg::MODE_UNUSED :
                (r < 6) ? famf_pkg::MODE_AVG : famf_pkg::MODE_MED;
            set_mode(m);
            calm = ($urandom_range(0, 3) == 0);
            length = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(5, 80);
            for (int k = 0; k < length; k++)
            begin
                send_item(pick_sample(), pick_sample(), $urandom_range(0, 4) != 0);
            end
            sent += length;
            calm = 1'b0;
        end

        settle();
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
